// ===== sv/voxel_brush_edit_engine_unit_assert.svh =====
// assertion macros for the voxel brush edit engine
`ifndef VOXEL_BRUSH_EDIT_ENGINE_UNIT_ASSERT_SVH
`define VOXEL_BRUSH_EDIT_ENGINE_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define VBE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define VBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/vbe_pkg.sv =====
// shared types, codes and constants of the voxel brush edit engine
`default_nettype none
package vbe_pkg;

  localparam int VBE_VOLUME_SIDE = 32;
  localparam int COORD_W = 5;
  localparam int VOX_W = 8;
  localparam int OP_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam int POS_W = 10;
  localparam int W_W = 9;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_BRUSH = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  localparam logic [1:0] FALL_BALL = 2'd0;
  localparam logic [1:0] FALL_CUBE = 2'd1;
  localparam logic [1:0] FALL_TUBE = 2'd2;

  localparam logic [1:0] EDIT_ADD = 2'd0;
  localparam logic [1:0] EDIT_CARVE = 2'd1;
  localparam logic [1:0] EDIT_BLUR = 2'd2;
  localparam logic [1:0] EDIT_NONE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SHAPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 2'd3;

  typedef struct packed {
    logic [1:0] shape;
    logic [7:0] radius;
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic [COORD_W-1:0] oz;
  } vbe_wreq_t;

endpackage
`default_nettype wire

// ===== sv/vbe_ifs.sv =====
// handshake channels for items, results and register writes
`default_nettype none
interface vbe_req_if;
  import vbe_pkg::*;
  logic valid;
  logic ready;
  logic [OP_W-1:0] op;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [COORD_W-1:0] coord_z;
  logic [VOX_W-1:0] write_value;
  modport source (output valid, op, coord_x, coord_y, coord_z, write_value, input ready);
  modport sink (input valid, op, coord_x, coord_y, coord_z, write_value, output ready);
endinterface

interface vbe_rsp_if;
  import vbe_pkg::*;
  logic valid;
  logic ready;
  logic [VOX_W-1:0] read_value;
  logic [OP_W-1:0] done_op;
  modport source (output valid, read_value, done_op, input ready);
  modport sink (input valid, read_value, done_op, output ready);
endinterface

interface vbe_cfg_if;
  import vbe_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/voxel_brush_edit_engine_unit.sv =====
// voxel brush edit engine: read, write and brush edits on a voxel volume ram
// reset: a clearing pass zeroes the volume, one voxel a cycle (side^3 voxels,
// 32768 at side 32); no item is taken meanwhile, register writes are taken
// write and read: one item at a time; a read waits in ST_RDWAIT before ST_DONE
// brush: (2t+1)^3 voxels, t = radius / 16; a voxel costs a weight search, and one of
// nonzero weight inside the volume also 27 neighbor reads on the one ram port
`default_nettype none
`include "voxel_brush_edit_engine_unit_assert.svh"
module voxel_brush_edit_engine_unit #(
  parameter int VOLUME_SIDE = vbe_pkg::VBE_VOLUME_SIDE
) (
  input logic clk,
  input logic rst,
  vbe_req_if.sink req,
  vbe_rsp_if.source rsp,
  vbe_cfg_if.sink cfg
);
  import vbe_pkg::*;

  localparam int DEPTH = VOLUME_SIDE * VOLUME_SIDE * VOLUME_SIDE;
  localparam int AW = $clog2(DEPTH);
  localparam int AVG_MUL = 10083;
  localparam int AVG_SH = 18;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RDWAIT, ST_WSTART, ST_WWAIT, ST_SCAN,
    ST_DRAIN, ST_CALC, ST_APPLY, ST_NEXT, ST_DONE
  } state_t;

  function automatic logic inside_vol(input logic signed [POS_W-1:0] x,
                                      input logic signed [POS_W-1:0] y,
                                      input logic signed [POS_W-1:0] z);
    inside_vol = !x[POS_W-1] && !y[POS_W-1] && !z[POS_W-1] &&
                 (x < POS_W'(VOLUME_SIDE)) && (y < POS_W'(VOLUME_SIDE)) &&
                 (z < POS_W'(VOLUME_SIDE));
  endfunction

  function automatic logic [AW-1:0] vidx(input logic signed [POS_W-1:0] x,
                                         input logic signed [POS_W-1:0] y,
                                         input logic signed [POS_W-1:0] z);
    vidx = AW'(z) * AW'(VOLUME_SIDE * VOLUME_SIDE) + AW'(y) * AW'(VOLUME_SIDE) + AW'(x);
  endfunction

  function automatic logic [VOX_W-1:0] clamp_q16(input logic signed [27:0] v);
    if (v < 0) begin
      clamp_q16 = '0;
    end else if (v[27:16] > 12'd255) begin
      clamp_q16 = 8'd255;
    end else begin
      clamp_q16 = v[23:16];
    end
  endfunction

  state_t state;
  logic [AW-1:0] clr_cnt;
  logic [1:0] brush_shape;
  logic [1:0] brush_tool;
  logic [7:0] brush_radius;
  logic signed [9:0] brush_strength;

  logic [COORD_W-1:0] cx, cy, cz;
  logic signed [COORD_W-1:0] ox, oy, oz;
  logic [1:0] ndx, ndy, ndz;
  logic sv_valid, sv_in, sv_ctr;
  logic rd_in;
  logic [12:0] sum;
  logic [VOX_W-1:0] cur;
  logic [VOX_W-1:0] avg;
  logic found;
  logic signed [18:0] p;
  logic [VOX_W-1:0] res_val;
  logic [OP_W-1:0] res_op;
  logic out_valid;
  logic [VOX_W-1:0] out_value;
  logic [OP_W-1:0] out_op;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [VOX_W-1:0] ram_wdata;
  logic [VOX_W-1:0] ram_rdata;

  vbe_wreq_t wreq;
  logic wstart;
  logic wdone;
  logic [W_W-1:0] weight;

  logic signed [POS_W-1:0] ix, iy, iz;
  logic signed [POS_W-1:0] tx, ty, tz;
  logic signed [POS_W-1:0] nx, ny, nz;
  logic in_ok, t_in, n_in, n_last;
  logic signed [COORD_W-1:0] t_s;
  logic ppos;
  logic [VOX_W-1:0] mark, sval;
  logic [26:0] avg_prod;
  logic signed [27:0] cur_q, p255, dv, smv;
  logic signed [9:0] diff;
  logic [8:0] absd;
  logic go;
  logic wr_en;
  logic [VOX_W-1:0] new_val;
  logic signed [9:0] cfg_s;

  vbe_ram #(.WIDTH(VOX_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  vbe_weight u_weight (
    .clk(clk), .rst(rst), .start(wstart), .wreq(wreq), .done(wdone), .weight(weight)
  );

  always_comb begin
    ix = signed'(POS_W'(req.coord_x));
    iy = signed'(POS_W'(req.coord_y));
    iz = signed'(POS_W'(req.coord_z));
    in_ok = inside_vol(ix, iy, iz);
    tx = POS_W'(signed'(POS_W'(cx)) + POS_W'(ox));
    ty = POS_W'(signed'(POS_W'(cy)) + POS_W'(oy));
    tz = POS_W'(signed'(POS_W'(cz)) + POS_W'(oz));
    t_in = inside_vol(tx, ty, tz);
    nx = POS_W'(tx + signed'(POS_W'(ndx)) - POS_W'(1));
    ny = POS_W'(ty + signed'(POS_W'(ndy)) - POS_W'(1));
    nz = POS_W'(tz + signed'(POS_W'(ndz)) - POS_W'(1));
    n_in = inside_vol(nx, ny, nz);
    n_last = (ndx == 2'd2) && (ndy == 2'd2) && (ndz == 2'd2);
    t_s = signed'({1'b0, brush_radius[7:4]});
    wstart = (state == ST_WSTART);
    wreq = '{shape: brush_shape, radius: brush_radius, ox: ox, oy: oy, oz: oz};

    ppos = !p[18] && (p != '0);
    mark = ppos ? 8'd255 : 8'd0;
    sval = sv_in ? ram_rdata : 8'd0;
    avg_prod = 27'(sum) * 27'(AVG_MUL);

    cur_q = signed'(28'({cur, 16'b0}));
    p255 = 28'(p) * 28'sd255;
    dv = cur_q + p255;
    diff = signed'({2'b0, avg}) - signed'({2'b0, cur});
    absd = diff[9] ? 9'(-diff) : diff[8:0];
    if (diff > 0) begin
      smv = cur_q + 28'(p);
    end else if (diff < 0) begin
      smv = cur_q - 28'(p);
    end else begin
      smv = cur_q;
    end
    go = found || (ppos ? (cur > 8'd127) : (cur < 8'd128));
    case (brush_tool)
      EDIT_ADD: begin
        wr_en = 1'b1;
        new_val = clamp_q16(dv);
      end
      EDIT_CARVE: begin
        wr_en = go;
        new_val = clamp_q16(dv);
      end
      EDIT_BLUR: begin
        wr_en = 1'b1;
        if (!p[18] && ({absd, 16'b0} <= {6'b0, p})) begin
          new_val = avg;
        end else begin
          new_val = clamp_q16(smv);
        end
      end
      default: begin
        wr_en = 1'b0;
        new_val = cur;
      end
    endcase

    ram_we = 1'b0;
    ram_addr = '0;
    ram_wdata = '0;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_cnt;
      end
      ST_IDLE: begin
        ram_addr = vidx(ix, iy, iz);
        ram_we = req.valid && (req.op == OP_WRITE) && in_ok;
        ram_wdata = req.write_value;
      end
      ST_SCAN: ram_addr = vidx(nx, ny, nz);
      ST_APPLY: begin
        ram_addr = vidx(tx, ty, tz);
        ram_we = wr_en;
        ram_wdata = new_val;
      end
      default: ram_addr = '0;
    endcase

    cfg_s = signed'(cfg.data);
    if (cfg_s > 10'sd256) begin
      cfg_s = 10'sd256;
    end else if (cfg_s < -10'sd256) begin
      cfg_s = -10'sd256;
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.done_op = out_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      brush_shape <= FALL_BALL;
      brush_tool <= EDIT_ADD;
      brush_radius <= 8'd64;
      brush_strength <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SHAPE: brush_shape <= cfg.data[1:0];
        REG_TOOL: brush_tool <= cfg.data[1:0];
        REG_RADIUS: begin
          if (cfg.data[7:0] != 8'd0) begin
            brush_radius <= cfg.data[7:0];
          end
        end
        REG_STRENGTH: brush_strength <= cfg_s;
        default: brush_shape <= brush_shape;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      sv_valid <= 1'b0;
    end else begin
      sv_valid <= (state == ST_SCAN);
      if ((state == ST_DONE) && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (sv_valid) begin
        if (sv_ctr) begin
          cur <= sval;
        end else begin
          sum <= 13'(sum + 13'(sval));
        end
        if (sval == mark) begin
          found <= 1'b1;
        end
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= AW'(clr_cnt + 1'b1);
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            res_op <= req.op;
            res_val <= '0;
            rd_in <= in_ok;
            cx <= req.coord_x;
            cy <= req.coord_y;
            cz <= req.coord_z;
            ox <= -t_s;
            oy <= -t_s;
            oz <= -t_s;
            case (req.op)
              OP_WRITE: state <= ST_DONE;
              OP_READ: state <= ST_RDWAIT;
              OP_BRUSH: state <= (brush_tool == EDIT_NONE) ? ST_DONE : ST_WSTART;
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_RDWAIT: begin
          res_val <= rd_in ? ram_rdata : 8'd0;
          state <= ST_DONE;
        end
        ST_WSTART: state <= ST_WWAIT;
        ST_WWAIT: begin
          if (wdone) begin
            if ((weight == '0) || !t_in) begin
              state <= ST_NEXT;
            end else begin
              p <= 19'(signed'({1'b0, weight}) * brush_strength);
              ndx <= '0;
              ndy <= '0;
              ndz <= '0;
              sum <= '0;
              found <= 1'b0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          sv_in <= n_in;
          sv_ctr <= (ndx == 2'd1) && (ndy == 2'd1) && (ndz == 2'd1);
          if (ndx != 2'd2) begin
            ndx <= ndx + 2'd1;
          end else begin
            ndx <= '0;
            if (ndy != 2'd2) begin
              ndy <= ndy + 2'd1;
            end else begin
              ndy <= '0;
              ndz <= ndz + 2'd1;
            end
          end
          if (n_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: state <= ST_CALC;
        ST_CALC: begin
          avg <= avg_prod[AVG_SH +: VOX_W];
          state <= ST_APPLY;
        end
        ST_APPLY: state <= ST_NEXT;
        ST_NEXT: begin
          state <= ST_WSTART;
          if (ox != t_s) begin
            ox <= ox + 5'sd1;
          end else begin
            ox <= -t_s;
            if (oy != t_s) begin
              oy <= oy + 5'sd1;
            end else begin
              oy <= -t_s;
              if (oz != t_s) begin
                oz <= oz + 5'sd1;
              end else begin
                state <= ST_DONE;
              end
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_value <= res_val;
            out_op <= res_op;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `VBE_ASSERT_NEXT(a_read_waits, clk, rst, req.valid && req.ready && (req.op == OP_READ), state == ST_RDWAIT, "read did not enter ram wait")
  `VBE_ASSERT_NOW(a_we_states, clk, rst, ram_we, (state == ST_CLEAR) || (state == ST_IDLE) || (state == ST_APPLY), "ram written outside a write state")
  `VBE_ASSERT_NOW(a_wdone_wait, clk, rst, wdone, state == ST_WWAIT, "weight finished while not awaited")
  `VBE_ASSERT_NEXT(a_result_loaded, clk, rst, (state == ST_DONE) && (!out_valid || rsp.ready), out_valid, "result not presented")

endmodule
`default_nettype wire

// ===== sv/vbe_ram.sv =====
// single port ram with registered read
`default_nettype none
module vbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== sv/vbe_weight.sv =====
// falloff weight unit, binary search with one compare per pass through W_SQ and W_CMP
`default_nettype none
module vbe_weight (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  vbe_pkg::vbe_wreq_t     wreq,
  output logic                   done,
  output logic [vbe_pkg::W_W-1:0] weight
);
  import vbe_pkg::*;

  typedef enum logic [1:0] {W_IDLE, W_PREP, W_SQ, W_CMP} wstate_t;

  wstate_t wstate;
  logic [1:0] shp;
  logic [7:0] rad;
  logic [9:0] s;
  logic [3:0] m;
  logic [15:0] r2;
  logic [15:0] coef;
  logic [8:0] lo;
  logic [8:0] hi;
  logic [16:0] factor;
  logic [33:0] need;

  logic [3:0] ax, ay, az, mxy;
  logic [9:0] s_next;
  logic [3:0] m_next;
  logic [8:0] mid;
  logic [32:0] prod;
  logic is_round;
  logic zero;

  always_comb begin
    ax = wreq.ox[4] ? 4'(-wreq.ox) : wreq.ox[3:0];
    ay = wreq.oy[4] ? 4'(-wreq.oy) : wreq.oy[3:0];
    az = wreq.oz[4] ? 4'(-wreq.oz) : wreq.oz[3:0];
    if (wreq.shape == FALL_TUBE) begin
      s_next = 10'(ax) * 10'(ax) + 10'(az) * 10'(az);
    end else begin
      s_next = 10'(ax) * 10'(ax) + 10'(ay) * 10'(ay) + 10'(az) * 10'(az);
    end
    mxy = (ay > ax) ? ay : ax;
    m_next = (az > mxy) ? az : mxy;
    mid = 9'((10'(lo) + 10'(hi)) >> 1);
    prod = 33'(coef) * 33'(factor);
    is_round = (shp == FALL_BALL) || (shp == FALL_TUBE);
    if (is_round) begin
      zero = ({s, 8'b0} >= {2'b0, r2});
    end else if (shp == FALL_CUBE) begin
      zero = ({m, 4'b0} >= rad);
    end else begin
      zero = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wstate <= W_IDLE;
      done <= 1'b0;
    end else begin
      done <= ((wstate == W_PREP) && zero) || ((wstate == W_SQ) && (lo == hi));
      case (wstate)
        W_IDLE: begin
          if (start) begin
            shp <= wreq.shape;
            rad <= wreq.radius;
            s <= s_next;
            m <= m_next;
            r2 <= 16'(wreq.radius) * 16'(wreq.radius);
            wstate <= W_PREP;
          end
        end
        W_PREP: begin
          if (zero) begin
            weight <= '0;
            wstate <= W_IDLE;
          end else begin
            lo <= '0;
            hi <= 9'd256;
            need <= is_round ? {s, 24'b0} : 34'({m, 12'b0});
            coef <= is_round ? r2 : 16'(rad);
            wstate <= W_SQ;
          end
        end
        W_SQ: begin
          if (lo == hi) begin
            weight <= 9'(9'd256 - lo);
            wstate <= W_IDLE;
          end else begin
            factor <= is_round ? 17'(mid) * 17'(mid) : 17'(mid);
            wstate <= W_CMP;
          end
        end
        W_CMP: begin
          if ({1'b0, prod} >= need) begin
            hi <= mid;
          end else begin
            lo <= 9'(mid + 9'd1);
          end
          wstate <= W_SQ;
        end
        default: wstate <= W_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
